FILE: design/ptp_pkg.sv
`default_nettype none

package ptp_pkg;

    // Default table geometry
    localparam int SLOTS_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;

    // Input transaction modes
    localparam logic MODE_SCHED = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Input transaction payload
    typedef struct packed {
        logic       mode;
        logic [3:0] slot;
        logic       present;
        logic       blocked;
        logic [7:0] priority_req;
    } t_in;

    // Result transaction payload
    typedef struct packed {
        logic [3:0] chosen_slot;
        logic       switched;
        logic       none_runnable;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic write;
        logic issue;
        logic finish;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;
    } t_ctl_sts;

endpackage

`default_nettype wire

FILE: design/ptp_ctrl.sv
`default_nettype none

module ptp_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  wire               i_mode,
    input  ptp_pkg::t_ctl_sts i_sts,
    output logic              busy,
    output ptp_pkg::t_ctl_cmd o_cmd
);
    import ptp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode state into commands and next state
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        busy         = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_mode == MODE_SCHED) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && i_sts.last |=> (r_state == S_DRAIN))
        else $error("scan did not end after the last slot");
`endif

endmodule

`default_nettype wire

FILE: design/ptp_datapath.sv
`default_nettype none

module ptp_datapath #(
    parameter int SLOTS     = ptp_pkg::SLOTS_DEF,
    parameter int PRIO_BITS = ptp_pkg::PRIO_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ptp_pkg::t_in      i_in,
    input  ptp_pkg::t_ctl_cmd i_cmd,
    output ptp_pkg::t_ctl_sts o_sts,
    output logic              o_done,
    output ptp_pkg::t_out     o_out
);
    import ptp_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Slot table: runnable bits in flops, priorities in memory
    logic [SLOTS-1:0]     r_run;
    logic [PRIO_BITS-1:0] r_prio_mem [SLOTS];

    logic [SLOT_W-1:0]    r_cur;
    logic [SLOT_W-1:0]    r_idx;
    logic [SLOT_W-1:0]    r_cnt;
    logic                 r_cmp_v;
    logic                 r_run_d;
    logic [SLOT_W-1:0]    r_idx_d;
    logic [PRIO_BITS-1:0] r_prio_d;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_best;
    logic [PRIO_BITS-1:0] r_best_prio;
    logic                 r_done;
    t_out                 r_out;

    logic                 wr_ok;
    logic [SLOT_W-1:0]    wr_addr;
    logic                 take;
    logic                 n_found;
    logic [SLOT_W-1:0]    n_best;
    logic [PRIO_BITS-1:0] n_best_prio;

    assign wr_ok   = i_cmd.write && (32'(i_in.slot) < SLOTS);
    assign wr_addr = SLOT_W'(i_in.slot);

    // Write one priority entry, read one per scan step
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_prio_mem[wr_addr] <= PRIO_BITS'(i_in.priority_req);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prio_d <= r_prio_mem[r_idx];
        end
    end

    // Runnable bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (wr_ok) begin
            r_run[wr_addr] <= i_in.present && !i_in.blocked;
        end
    end

    // Walk the slots in rotating order
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;
            r_cnt <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.issue) begin
            r_run_d <= r_run[r_idx];
            r_idx_d <= r_idx;
        end
    end

    assign o_sts.last = (r_cnt == LAST_SLOT);

    // Keep the first strictly lowest runnable priority
    always_comb begin
        take        = r_cmp_v && r_run_d && (!r_found || (r_prio_d < r_best_prio));
        n_found     = r_found || take;
        n_best      = take ? r_idx_d : r_best;
        n_best_prio = take ? r_prio_d : r_best_prio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.issue;
            r_found <= i_cmd.load ? 1'b0 : n_found;
        end
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
    end

    // Register the result and advance the current slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.finish && n_found) begin
                r_cur <= n_best;
            end
        end
        if (i_cmd.finish) begin
            r_out.chosen_slot   <= n_found ? 4'(n_best) : 4'(r_cur);
            r_out.switched      <= n_found && (n_best != r_cur);
            r_out.none_runnable <= !n_found;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef NO_ASSERTIONS
    a_finish_has_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_cmp_v)
        else $error("finish without the last comparison pending");

    a_pick_runnable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !r_out.none_runnable |-> r_run[r_cur])
        else $error("picked slot is not runnable");

    a_switch_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_out.switched |-> !r_out.none_runnable)
        else $error("switch reported with no runnable slot");
`endif

endmodule

`default_nettype wire

FILE: design/priority_thread_picker_unit.sv
`default_nettype none

// Priority thread picker.
// Input channel: an input transaction is taken at a rising edge with start
// high and busy low. i_in.mode selects a slot write or a schedule request.
// A write stores present, blocked and priority for one slot, gives no
// result and leaves busy low; writes to slots at or beyond SLOTS are
// dropped. A schedule request walks all SLOTS entries through one
// priority comparator, one slot per cycle out of the priority memory read
// port, then a drain step registers the result; busy stays high through
// the scan and the drain. A new request can be taken in the same cycle
// that the result is shown.
// Result channel: o_done is high for exactly one cycle with o_out valid;
// the receiver cannot stall, so each result must be taken in that cycle.
// Reset (synchronous, active low) marks every slot empty and makes slot
// zero current; it takes effect at once, with no clearing sweep.
module priority_thread_picker_unit #(
    parameter int SLOTS     = ptp_pkg::SLOTS_DEF,
    parameter int PRIO_BITS = ptp_pkg::PRIO_BITS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    input  ptp_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_done,
    output ptp_pkg::t_out o_out
);
    import ptp_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // Sequence the scan
    ptp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_in.mode),
        .i_sts   (sts),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Hold the slot table and compare priorities
    ptp_datapath #(
        .SLOTS     (SLOTS),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_done  (o_done),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_in.mode == MODE_SCHED) |=> busy)
        else $error("schedule request did not raise busy");
`endif

endmodule

`default_nettype wire
